FILE: src/ris_pkg.sv
// shared types, constants and functions of the random index sampler
package ris_pkg;

  localparam int POOL_DEPTH_DEF  = 1024;
  localparam int MAX_SAMPLES_DEF = 64;

  localparam int TW_N   = 312;
  localparam int TW_M   = 156;
  localparam int TW_AW  = $clog2(TW_N);
  localparam logic [63:0] TW_MATRIX = 64'hB5026F5AA96619E9;
  localparam logic [63:0] TW_UPPER  = 64'hFFFFFFFF80000000;
  localparam logic [63:0] TW_LOWER  = 64'h000000007FFFFFFF;
  localparam logic [63:0] TW_MULT   = 64'd6364136223846793005;

  // width of the request tag stored beside each pool entry
  localparam int EPW = 8;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_COUNT = 3'd2;
  localparam logic [2:0] ST_POOL  = 3'd3;
  localparam logic [2:0] ST_NONE  = 3'd4;

  typedef struct packed {
    logic [31:0] range_start;
    logic [31:0] range_end;
    logic [6:0]  sample_count;
    logic [63:0] seed_value;
  } req_t;

  typedef struct packed {
    logic [31:0] sampled_index;
    logic [2:0]  status_code;
    logic        last_of_run;
  } rsp_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] start;
    logic [31:0] avail;
    logic [6:0]  count;
    logic [63:0] seed;
  } cmd_t;

  function automatic logic [63:0] tw_temper(input logic [63:0] w);
    logic [63:0] x;
    x = w;
    x = x ^ ((x >> 29) & 64'h5555555555555555);
    x = x ^ ((x << 17) & 64'h71D67FFFEDA60000);
    x = x ^ ((x << 37) & 64'hFFF7EEE000000000);
    x = x ^ (x >> 43);
    return x;
  endfunction

endpackage

FILE: src/random_index_sampler_core.sv
// top level of the random index sampler
//
// one request (start, end, count, seed) yields count distinct indices of
// [start, end) in ascending order, the last one flagged, or one beat with an
// error or "none" status. a valid request seeds the 64-bit twister through one
// shared 32x32 multiplier, regenerates its 312 words through the single read
// port of the state memory, then for each draw runs a bit-serial 64-bit
// modulo and the pool swap, and finally emits one output beat per index.
// after reset, and again once every 255 valid requests, a clearing pass
// sweeps the pool tags; requests queue meanwhile. a two-entry queue sits
// between intake and execution, and the output register lets execution run
// on while a beat waits to be taken.
module random_index_sampler_core #(
  parameter int POOL_DEPTH  = ris_pkg::POOL_DEPTH_DEF,
  parameter int MAX_SAMPLES = ris_pkg::MAX_SAMPLES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  ris_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output ris_pkg::rsp_t rsp
);

  // classified commands between the two halves
  logic          cmd_valid;
  logic          cmd_pop;
  ris_pkg::cmd_t cmd;

  ris_front #(.POOL_DEPTH(POOL_DEPTH), .MAX_SAMPLES(MAX_SAMPLES)) u_front (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
  );

  ris_back #(.POOL_DEPTH(POOL_DEPTH), .MAX_SAMPLES(MAX_SAMPLES)) u_back (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

endmodule

FILE: src/ris_ram.sv
// generic single write, single registered read memory
module ris_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/ris_front.sv
// request intake: range checks and a two-entry command queue
module ris_front #(
  parameter int POOL_DEPTH  = ris_pkg::POOL_DEPTH_DEF,
  parameter int MAX_SAMPLES = ris_pkg::MAX_SAMPLES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  ris_pkg::req_t req,
  output logic          cmd_valid,
  output ris_pkg::cmd_t cmd,
  input  logic          cmd_pop
);

  ris_pkg::cmd_t q [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;
  ris_pkg::cmd_t cls;
  logic          push;

  always_comb begin
    cls.start = req.range_start;
    cls.avail = req.range_end - req.range_start;
    cls.count = req.sample_count;
    cls.seed  = req.seed_value;
    if (req.range_start >= req.range_end) begin
      cls.status = ris_pkg::ST_EMPTY;
    end else if (32'(req.sample_count) > cls.avail ||
                 32'(req.sample_count) > 32'(MAX_SAMPLES)) begin
      cls.status = ris_pkg::ST_COUNT;
    end else if (cls.avail > 32'(POOL_DEPTH)) begin
      cls.status = ris_pkg::ST_POOL;
    end else if (req.sample_count == 7'd0) begin
      cls.status = ris_pkg::ST_NONE;
    end else begin
      cls.status = ris_pkg::ST_OK;
    end
  end

  assign req_stall = (fill == 2'd2);
  assign push      = req_valid && !req_stall;
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(cmd_pop);
    end
  end

endmodule

FILE: src/ris_back.sv
// request execution: twister, serial modulo, pool shuffle, sort and emission
module ris_back #(
  parameter int POOL_DEPTH  = ris_pkg::POOL_DEPTH_DEF,
  parameter int MAX_SAMPLES = ris_pkg::MAX_SAMPLES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  ris_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output ris_pkg::rsp_t rsp
);

  localparam int PW  = $clog2(POOL_DEPTH);
  localparam int AVW = $clog2(POOL_DEPTH + 1);
  localparam int TAW = ris_pkg::TW_AW;
  localparam int EPW = ris_pkg::EPW;

  typedef enum logic [8:0] {
    S_CLR   = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_SEED  = 9'b000000100,
    S_REGEN = 9'b000001000,
    S_DRAW  = 9'b000010000,
    S_MOD   = 9'b000100000,
    S_POOL  = 9'b001000000,
    S_EMIT  = 9'b010000000,
    S_ERR   = 9'b100000000
  } state_t;

  state_t          state;
  logic [2:0]      step;
  logic [TAW-1:0]  idx;
  logic [PW-1:0]   clr_addr;
  logic [EPW-1:0]  epoch;
  logic [31:0]     start;
  logic [AVW-1:0]  avail;
  logic [6:0]      count;
  logic [63:0]     seed;
  logic [2:0]      err_status;
  logic [6:0]      i;
  logic [63:0]     p;
  logic [63:0]     pp0;
  logic [31:0]     hi;
  logic [63:0]     prod;
  logic [63:0]     ra;
  logic [63:0]     rb;
  logic [63:0]     x;
  logic [AVW-1:0]  d;
  logic [AVW-1:0]  rem;
  logic [5:0]      bit_cnt;
  logic [PW-1:0]   j;
  logic [PW-1:0]   a_val;
  logic [PW-1:0]   sbuf [MAX_SAMPLES];
  logic [6:0]      n;

  // twister memory
  logic             mt_we;
  logic [TAW-1:0]   mt_waddr;
  logic [63:0]      mt_wdata;
  logic [TAW-1:0]   mt_raddr;
  logic [63:0]      mt_rdata;
  // pool memory: tag and offset
  logic             pl_we;
  logic [PW-1:0]    pl_waddr;
  logic [EPW+PW-1:0] pl_wdata;
  logic [PW-1:0]    pl_raddr;
  logic [EPW+PW-1:0] pl_rdata;

  logic [63:0]     sa;
  logic [31:0]     mul_a;
  logic [31:0]     mul_b;
  logic [63:0]     seed_w;
  logic [63:0]     tx;
  logic [63:0]     ty;
  logic [TAW-1:0]  idx_n1;
  logic [TAW-1:0]  idx_m;
  logic [AVW:0]    mod_t;
  logic [AVW:0]    mod_s;
  logic [PW-1:0]   b_val;
  logic [PW-1:0]   a_dec;
  logic            lt [MAX_SAMPLES];
  logic            slot_free;

  ris_ram #(.WIDTH(64), .DEPTH(ris_pkg::TW_N)) u_mt_ram (
    .clk(clk), .we(mt_we), .waddr(mt_waddr), .wdata(mt_wdata),
    .raddr(mt_raddr), .rdata(mt_rdata)
  );

  ris_ram #(.WIDTH(EPW + PW), .DEPTH(POOL_DEPTH)) u_pool_ram (
    .clk(clk), .we(pl_we), .waddr(pl_waddr), .wdata(pl_wdata),
    .raddr(pl_raddr), .rdata(pl_rdata)
  );

  assign sa     = p ^ (p >> 62);
  assign seed_w = pp0 + {hi, 32'h0} + 64'(idx);
  assign tx     = (ra & ris_pkg::TW_UPPER) | (rb & ris_pkg::TW_LOWER);
  assign ty     = tx[0] ? ((tx >> 1) ^ ris_pkg::TW_MATRIX) : (tx >> 1);
  assign idx_n1 = (idx == TAW'(ris_pkg::TW_N - 1)) ? '0 : idx + 1'b1;
  assign idx_m  = (idx >= TAW'(ris_pkg::TW_N - ris_pkg::TW_M)) ?
                  idx - TAW'(ris_pkg::TW_N - ris_pkg::TW_M) :
                  idx + TAW'(ris_pkg::TW_M);
  assign mod_t  = {rem, x[63]};
  assign mod_s  = (mod_t >= {1'b0, d}) ? mod_t - {1'b0, d} : mod_t;
  // untouched entries read as their own offset
  assign a_dec  = (pl_rdata[EPW+PW-1:PW] == epoch) ? pl_rdata[PW-1:0] : PW'(i);
  assign b_val  = (pl_rdata[EPW+PW-1:PW] == epoch) ? pl_rdata[PW-1:0] : j;
  assign slot_free = !rsp_valid || !rsp_stall;

  always_comb begin
    case (step)
      3'd0:    begin mul_a = sa[31:0];  mul_b = ris_pkg::TW_MULT[31:0];  end
      3'd1:    begin mul_a = sa[31:0];  mul_b = ris_pkg::TW_MULT[63:32]; end
      default: begin mul_a = sa[63:32]; mul_b = ris_pkg::TW_MULT[31:0];  end
    endcase
  end

  always_comb begin
    mt_we    = 1'b0;
    mt_waddr = idx;
    mt_wdata = seed_w;
    mt_raddr = '0;
    pl_we    = 1'b0;
    pl_waddr = clr_addr;
    pl_wdata = '0;
    pl_raddr = '0;
    case (state)
      S_CLR: begin
        pl_we = 1'b1;
      end
      S_SEED: begin
        if (idx == '0) begin
          mt_we    = 1'b1;
          mt_wdata = seed;
        end else if (step == 3'd4) begin
          mt_we = 1'b1;
        end
      end
      S_REGEN: begin
        case (step)
          3'd0:    mt_raddr = idx;
          3'd1:    mt_raddr = idx_n1;
          3'd2:    mt_raddr = idx_m;
          default: begin
            mt_we    = 1'b1;
            mt_wdata = mt_rdata ^ ty;
          end
        endcase
      end
      S_DRAW: begin
        mt_raddr = TAW'(i);
      end
      S_POOL: begin
        case (step)
          3'd0:    pl_raddr = PW'(i);
          3'd1:    pl_raddr = j;
          3'd2: begin
            pl_we    = 1'b1;
            pl_waddr = PW'(i);
            pl_wdata = {epoch, b_val};
          end
          default: begin
            pl_we    = 1'b1;
            pl_waddr = j;
            pl_wdata = {epoch, a_val};
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // entries below the insertion point stay, the rest move up one
  always_comb begin
    for (int k = 0; k < MAX_SAMPLES; k++) begin
      lt[k] = (7'(k) < n) && (sbuf[k] < b_val);
    end
  end

  assign cmd_pop = (state == S_IDLE) && cmd_valid &&
                   !(cmd.status == ris_pkg::ST_OK && epoch == '1);

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      state     <= S_CLR;
      step      <= '0;
      clr_addr  <= '0;
      epoch     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (slot_free && (state == S_EMIT || state == S_ERR)) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == PW'(POOL_DEPTH - 1)) begin
            clr_addr <= '0;
            epoch    <= '0;
            state    <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            start      <= cmd.start;
            avail      <= AVW'(cmd.avail);
            count      <= cmd.count;
            seed       <= cmd.seed;
            err_status <= cmd.status;
            if (cmd.status != ris_pkg::ST_OK) begin
              state <= S_ERR;
            end else if (epoch == '1) begin
              state <= S_CLR;
            end else begin
              epoch <= epoch + 1'b1;
              idx   <= '0;
              step  <= '0;
              state <= S_SEED;
            end
          end
        end
        S_SEED: begin
          if (idx == '0) begin
            p    <= seed;
            idx  <= idx + 1'b1;
            step <= '0;
          end else begin
            step <= step + 1'b1;
            case (step)
              3'd1: pp0 <= prod;
              3'd2: hi  <= prod[31:0];
              3'd3: hi  <= hi + prod[31:0];
              3'd4: begin
                p    <= seed_w;
                step <= '0;
                idx  <= idx + 1'b1;
                if (idx == TAW'(ris_pkg::TW_N - 1)) begin
                  idx   <= '0;
                  state <= S_REGEN;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_REGEN: begin
          step <= step + 1'b1;
          case (step)
            3'd1: ra <= mt_rdata;
            3'd2: rb <= mt_rdata;
            3'd3: begin
              step <= '0;
              idx  <= idx + 1'b1;
              if (idx == TAW'(ris_pkg::TW_N - 1)) begin
                i     <= '0;
                n     <= '0;
                state <= S_DRAW;
              end
            end
            default: begin
            end
          endcase
        end
        S_DRAW: begin
          step <= step + 1'b1;
          if (step != '0) begin
            x       <= ris_pkg::tw_temper(mt_rdata);
            d       <= avail - AVW'(i);
            rem     <= '0;
            bit_cnt <= '0;
            step    <= '0;
            state   <= S_MOD;
          end
        end
        S_MOD: begin
          // one quotient bit per cycle, msb first
          rem     <= AVW'(mod_s);
          x       <= x << 1;
          bit_cnt <= bit_cnt + 1'b1;
          if (bit_cnt == 6'd63) begin
            state <= S_POOL;
          end
        end
        S_POOL: begin
          step <= step + 1'b1;
          case (step)
            3'd0: j     <= PW'(i) + PW'(rem);
            3'd1: a_val <= a_dec;
            3'd2: begin
              for (int k = 0; k < MAX_SAMPLES; k++) begin
                if (!lt[k]) begin
                  sbuf[k] <= (k == 0 || lt[(k == 0) ? 0 : k - 1]) ? b_val :
                             sbuf[(k == 0) ? 0 : k - 1];
                end
              end
              n <= n + 1'b1;
            end
            default: begin
              step <= '0;
              i    <= i + 1'b1;
              if (i + 1'b1 == count) begin
                state <= S_EMIT;
              end else begin
                state <= S_DRAW;
              end
            end
          endcase
        end
        S_EMIT: begin
          if (slot_free) begin
            rsp.sampled_index <= start + 32'(sbuf[0]);
            rsp.status_code   <= ris_pkg::ST_OK;
            rsp.last_of_run   <= (n == 7'd1);
            for (int k = 0; k < MAX_SAMPLES - 1; k++) begin
              sbuf[k] <= sbuf[k + 1];
            end
            n <= n - 1'b1;
            if (n == 7'd1) begin
              state <= S_IDLE;
            end
          end
        end
        S_ERR: begin
          if (slot_free) begin
            rsp.sampled_index <= '0;
            rsp.status_code   <= err_status;
            rsp.last_of_run   <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLR;
        end
      endcase
    end
  end

endmodule
